### hdl/pals_pkg.sv
// ----------------------------------------------------------------------------
// pals_pkg
// Shared widths, register map and reset values for the parabola arc length
// block.
// ----------------------------------------------------------------------------
package pals_pkg;

  localparam int COORD_W  = 32;   // Q16.16 coordinates and coefficient
  localparam int COUNT_W  = 11;   // interval count
  localparam int ARC_W    = 48;   // Q32.16 result
  localparam int WORD_W   = 32;   // multiplier operand width
  localparam int Q_W      = ARC_W + 2;
  localparam int ADDR_W   = 3;
  localparam int DATA_W   = 32;

  // Register index on the configuration port
  localparam logic [ADDR_W-3:0] REG_COEF = '0;

  localparam logic [COORD_W-1:0] COEF_RESET = 32'h0001_0000;

  localparam logic [Q_W-1:0] NEG_LIMIT = Q_W'(1) << (ARC_W - 1);
  localparam logic [Q_W-1:0] POS_LIMIT = NEG_LIMIT - Q_W'(1);

endpackage

### hdl/parabola_arc_length_simpson.sv
// ----------------------------------------------------------------------------
// parabola_arc_length_simpson
// Arc length of z = c*t^2 between two points by composite Simpson's rule,
// built round one shared 32x32 multiplier and a bit-serial square root.
// ----------------------------------------------------------------------------
// Run time is set mainly by the bit-serial square root (one bit per cycle)
//   at each of the n+1 nodes (n = interval count); at FRAC_BITS = 16 the
//   inputs are Q16.16. Bad counts (zero, odd or above MAX_INTERVALS) return
//   a zero length with error_flag set. One transaction at a time.
// Reset: synchronous, clears the sequencer and output valid, and loads the
//   coefficient register with 1.0.
// ----------------------------------------------------------------------------
module parabola_arc_length_simpson #(
  parameter int MAX_INTERVALS = 1024,
  parameter int FRAC_BITS     = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // request channel
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [pals_pkg::COORD_W-1:0]  start_point,
  input  logic signed [pals_pkg::COORD_W-1:0]  end_point,
  input  logic [pals_pkg::COUNT_W-1:0]         interval_count,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [pals_pkg::ARC_W-1:0]    path_length,
  output logic                                 error_flag,
  // configuration port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [pals_pkg::ADDR_W-1:0]          paddr,
  input  logic [pals_pkg::DATA_W-1:0]          pwdata,
  output logic [pals_pkg::DATA_W-1:0]          prdata,
  output logic                                 pready
);

  import pals_pkg::*;

  // Widths derived from the fraction format
  localparam int GW    = 64 - FRAC_BITS;            // slope g
  localparam int VW    = 2 * GW;                    // radicand
  localparam int FW    = GW + 1;                    // integrand f
  localparam int N3_W  = COUNT_W + 2;               // 3*n
  localparam int SW    = FW + N3_W;                 // Simpson sum
  localparam int CH    = (SW + WORD_W - 1) / WORD_W; // sum chunks
  localparam int SPW   = CH * WORD_W;
  localparam int PW    = SPW + WORD_W;              // sum * |b-a|
  localparam int DW    = N3_W + FRAC_BITS;          // divisor 3n << F
  localparam int CNT_W = $clog2(PW + 1);

  localparam logic [64:0]   ROUND_HALF = 65'(1) << (FRAC_BITS - 1);
  localparam logic [VW-1:0] ONE_SQ     = VW'(1) << (2 * FRAC_BITS);

  typedef enum logic [3:0] {
    ST_IDLE, ST_DQ, ST_NODE, ST_SLOPE, ST_SQ_LL, ST_SQ_LH, ST_SQ_HH,
    ST_SQ_END, ST_ROOT_GO, ST_ROOT, ST_ACC, ST_MUL, ST_DIV, ST_ROUND, ST_DONE
  } state_t;

  state_t state;

  // Configuration
  logic [COORD_W-1:0] coef;
  logic               cfg_wr;

  // Request context
  logic signed [COORD_W-1:0] a_r;
  logic                      neg;
  logic [COORD_W-1:0]        d;
  logic [COUNT_W-1:0]        n;
  logic [COORD_W-1:0]        abs_c;

  // Node stepping: offset = round(d*i/n) kept as quotient and remainder
  logic [COORD_W-1:0] dsh;       // d shifts out, d/n shifts in
  logic [COUNT_W:0]   dq_rem;
  logic [COORD_W:0]   off_q;
  logic [COUNT_W-1:0] off_r;
  logic [COUNT_W-1:0] idx;
  logic [CNT_W-1:0]   cnt;

  // Shared datapath
  logic [WORD_W-1:0]  mul_a;
  logic [WORD_W-1:0]  mul_b;
  logic [63:0]        mul_p;
  logic [63:0]        mprod;
  logic [GW-1:0]      g;
  logic [VW-1:0]      vacc;
  logic [SPW-1:0]     sum;
  logic [PW-1:0]      prod;
  logic [DW-1:0]      drem;
  logic [Q_W-1:0]     q;
  logic               sat;

  // Pending result
  logic [ARC_W-1:0]   res_arc;
  logic               res_err;

  // Square root unit
  logic               sq_start;
  logic               sq_done;
  logic [FW-1:0]      f;

  // Combinational helpers
  logic signed [COORD_W:0] diff;
  logic                    bad_count;
  logic [COUNT_W:0]        dq_t;
  logic                    dq_fit;
  logic [COUNT_W:0]        rs;
  logic                    wrap;
  logic signed [COORD_W+1:0] t;
  logic [COORD_W-1:0]      tmag;
  logic [64:0]             g_full;
  logic [WORD_W-1:0]       gl;
  logic [WORD_W-1:0]       gh;
  logic [1:0]              wsh;
  logic [WORD_W-1:0]       chunk;
  logic [N3_W-1:0]         n3;
  logic [DW-1:0]           divisor;
  logic [DW:0]             dv_t;
  logic                    dv_fit;
  logic [Q_W-1:0]          q_t;
  logic [Q_W-1:0]          q_rnd;
  logic [Q_W-1:0]          mag;

  assign pready   = 1'b1;
  assign in_ready = (state == ST_IDLE);
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign prdata   = (paddr[ADDR_W-1:2] == REG_COEF) ? DATA_W'(coef) : '0;
  assign sq_start = (state == ST_ROOT_GO);

  always_comb begin
    diff      = {end_point[COORD_W-1], end_point} - {start_point[COORD_W-1], start_point};
    bad_count = (interval_count == '0) || interval_count[0] ||
                (int'(interval_count) > MAX_INTERVALS);

    // restoring divide step for d / n
    dq_t   = {dq_rem[COUNT_W-1:0], dsh[COORD_W-1]};
    dq_fit = dq_t >= {1'b0, n};

    // next node offset: add d/n and d%n, carry when remainder wraps
    rs   = {1'b0, off_r} + {1'b0, dq_rem[COUNT_W-1:0]};
    wrap = rs >= {1'b0, n};

    // node position and its magnitude
    if (neg) begin
      t = {a_r[COORD_W-1], a_r[COORD_W-1], a_r} - {1'b0, off_q};
    end else begin
      t = {a_r[COORD_W-1], a_r[COORD_W-1], a_r} + {1'b0, off_q};
    end
    tmag = t[COORD_W+1] ? COORD_W'(-t) : t[COORD_W-1:0];

    // g = round(2*|c|*|t| / 2^F), ties up
    g_full = {mprod, 1'b0} + ROUND_HALF;
    gl     = g[WORD_W-1:0];
    gh     = WORD_W'(g[GW-1:WORD_W]);

    // Simpson weights 1, 4, 2 as shifts
    if (idx == '0 || idx == n) begin
      wsh = 2'd0;
    end else if (idx[0]) begin
      wsh = 2'd2;
    end else begin
      wsh = 2'd1;
    end

    // sum chunks go through the multiplier most significant first
    chunk = '0;
    for (int k = 0; k < CH; k++) begin
      if (cnt == CNT_W'(CH - 1 - k)) begin
        chunk = sum[WORD_W*k +: WORD_W];
      end
    end

    // long division of the product by 3n << F
    n3      = ({2'b00, n} << 1) + {2'b00, n};
    divisor = {n3, {FRAC_BITS{1'b0}}};
    dv_t    = {drem, prod[PW-1]};
    dv_fit  = dv_t >= {1'b0, divisor};
    q_t     = {q[Q_W-2:0], dv_fit};

    q_rnd = q + Q_W'({drem, 1'b0} >= {1'b0, divisor});
    if (neg) begin
      mag = (sat || q_rnd > NEG_LIMIT) ? NEG_LIMIT : q_rnd;
    end else begin
      mag = (sat || q_rnd > POS_LIMIT) ? POS_LIMIT : q_rnd;
    end

    // shared multiplier operand select
    unique case (state)
      ST_NODE: begin
        mul_a = abs_c;
        mul_b = tmag;
      end
      ST_SQ_LL: begin
        mul_a = gl;
        mul_b = gl;
      end
      ST_SQ_LH: begin
        mul_a = gl;
        mul_b = gh;
      end
      ST_SQ_HH: begin
        mul_a = gh;
        mul_b = gh;
      end
      ST_MUL: begin
        mul_a = chunk;
        mul_b = d;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  pals_sqrt #(
    .ROOT_W (GW)
  ) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (vacc),
    .done     (sq_done),
    .root     (f)
  );

  // Coefficient register
  always_ff @(posedge clk) begin
    if (rst) begin
      coef <= COEF_RESET;
    end else if (cfg_wr && paddr[ADDR_W-1:2] == REG_COEF) begin
      coef <= pwdata[COORD_W-1:0];
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      cnt       <= '0;
    end else begin
      // ST_DONE reloads the output itself
      if (out_valid && out_ready && state != ST_DONE) begin
        out_valid <= 1'b0;
      end
      mprod <= mul_p;

      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            a_r   <= start_point;
            neg   <= diff[COORD_W];
            d     <= diff[COORD_W] ? COORD_W'(-diff) : diff[COORD_W-1:0];
            dsh   <= diff[COORD_W] ? COORD_W'(-diff) : diff[COORD_W-1:0];
            n     <= interval_count;
            abs_c <= coef[COORD_W-1] ? -coef : coef;
            dq_rem <= '0;
            cnt    <= '0;
            if (bad_count) begin
              res_arc <= '0;
              res_err <= 1'b1;
              state   <= ST_DONE;
            end else begin
              res_err <= 1'b0;
              state   <= ST_DQ;
            end
          end
        end

        ST_DQ: begin
          dq_rem <= dq_fit ? dq_t - {1'b0, n} : dq_t;
          dsh    <= {dsh[COORD_W-2:0], dq_fit};
          cnt    <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(COORD_W - 1)) begin
            off_q <= '0;
            off_r <= n >> 1;
            idx   <= '0;
            sum   <= '0;
            state <= ST_NODE;
          end
        end

        ST_NODE:  state <= ST_SLOPE;

        ST_SLOPE: begin
          g     <= g_full[FRAC_BITS +: GW];
          state <= ST_SQ_LL;
        end

        ST_SQ_LL: state <= ST_SQ_LH;

        ST_SQ_LH: begin
          vacc  <= VW'(mprod) + ONE_SQ;
          state <= ST_SQ_HH;
        end

        ST_SQ_HH: begin
          vacc  <= vacc + (VW'(mprod) << (WORD_W + 1));
          state <= ST_SQ_END;
        end

        ST_SQ_END: begin
          vacc  <= vacc + (VW'(mprod) << (2 * WORD_W));
          state <= ST_ROOT_GO;
        end

        ST_ROOT_GO: state <= ST_ROOT;

        ST_ROOT: begin
          if (sq_done) begin
            state <= ST_ACC;
          end
        end

        ST_ACC: begin
          sum <= sum + (SPW'(f) << wsh);
          if (idx == n) begin
            cnt   <= '0;
            prod  <= '0;
            state <= ST_MUL;
          end else begin
            idx   <= idx + COUNT_W'(1);
            off_q <= off_q + {1'b0, dsh} + (COORD_W+1)'(wrap);
            off_r <= wrap ? COUNT_W'(rs - {1'b0, n}) : rs[COUNT_W-1:0];
            state <= ST_NODE;
          end
        end

        ST_MUL: begin
          // prod = (prod << 32) + previous partial product
          if (cnt != '0) begin
            prod <= {prod[PW-WORD_W-1:0], {WORD_W{1'b0}}} + PW'(mprod);
          end
          if (cnt == CNT_W'(CH)) begin
            cnt   <= '0;
            drem  <= '0;
            q     <= '0;
            sat   <= 1'b0;
            state <= ST_DIV;
          end else begin
            cnt <= cnt + CNT_W'(1);
          end
        end

        ST_DIV: begin
          drem <= dv_fit ? DW'(dv_t - {1'b0, divisor}) : dv_t[DW-1:0];
          prod <= prod << 1;
          if (q_t > NEG_LIMIT) begin
            q   <= NEG_LIMIT;
            sat <= 1'b1;
          end else begin
            q <= q_t;
          end
          cnt <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(PW - 1)) begin
            state <= ST_ROUND;
          end
        end

        ST_ROUND: begin
          res_arc <= neg ? -mag[ARC_W-1:0] : mag[ARC_W-1:0];
          state   <= ST_DONE;
        end

        ST_DONE: begin
          if (!out_valid || out_ready) begin
            path_length <= res_arc;
            error_flag  <= res_err;
            out_valid   <= 1'b1;
            state       <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

  // Checks
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && error_flag |-> path_length == '0)
    else $error("error transaction with non-zero length");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

  a_root_timing: assert property (@(posedge clk) disable iff (rst)
    sq_done |-> state == ST_ROOT)
    else $error("square root finished outside its wait state");

endmodule

### hdl/pals_sqrt.sv
// ----------------------------------------------------------------------------
// pals_sqrt
// Bit-serial integer square root, one result bit per cycle, rounded to
// nearest at the end.
// ----------------------------------------------------------------------------
module pals_sqrt #(
  parameter int ROOT_W = 48
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [2*ROOT_W-1:0]   radicand,
  output logic                  done,
  output logic [ROOT_W:0]       root
);

  localparam int CW = $clog2(ROOT_W + 1);

  logic [2*ROOT_W-1:0] rad;
  logic [ROOT_W-1:0]   rt;
  logic [ROOT_W+1:0]   rem;
  logic [CW-1:0]       cnt;
  logic                busy;

  logic [ROOT_W+3:0]   rem_t;
  logic [ROOT_W+3:0]   trial;
  logic [ROOT_W+3:0]   rem_sub;
  logic                fits;

  always_comb begin
    rem_t   = {rem, rad[2*ROOT_W-1 -: 2]};
    trial   = {2'b00, rt, 2'b01};
    fits    = rem_t >= trial;
    rem_sub = rem_t - trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      if (start) begin
        rad  <= radicand;
        rt   <= '0;
        rem  <= '0;
        cnt  <= '0;
        busy <= 1'b1;
        done <= 1'b0;
      end else if (busy) begin
        if (cnt == CW'(ROOT_W)) begin
          // round to nearest: remainder above root means past the midpoint
          if (rem > {2'b00, rt}) begin
            root <= {1'b0, rt} + (ROOT_W+1)'(1);
          end else begin
            root <= {1'b0, rt};
          end
          done <= 1'b1;
          busy <= 1'b0;
        end else begin
          rem  <= fits ? rem_sub[ROOT_W+1:0] : rem_t[ROOT_W+1:0];
          rt   <= {rt[ROOT_W-2:0], fits};
          rad  <= rad << 2;
          cnt  <= cnt + CW'(1);
          done <= 1'b0;
        end
      end else begin
        done <= 1'b0;
      end
    end
  end

endmodule
